### rtl/vtpd_pkg.sv
// ----------------------------------------------------------------------------
// vtpd_pkg
// Item types and request codes for the vertex transform / perspective divide.
// ----------------------------------------------------------------------------
`default_nettype none

package vtpd_pkg;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_XFORM = 1'b1;

    typedef struct packed {
        logic               req_type;
        logic        [3:0]  entry_index;
        logic signed [31:0] entry_value;
        logic signed [31:0] vertex_x;
        logic signed [31:0] vertex_y;
        logic signed [31:0] vertex_z;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic               w_zero;
        logic               saturated;
    } t_out_item;

endpackage

`default_nettype wire

### rtl/vertex_transform_perspective_divide.sv
// ----------------------------------------------------------------------------
// vertex_transform_perspective_divide
// 4x4 fixed-point vertex transform followed by a perspective divide.
// ----------------------------------------------------------------------------
// Takes one item per clock. A load item writes one matrix entry and gives no
// result; a transform item gives one result, which passes through the input,
// product, sum and clamp registers, the divider stages and the result
// register. The divider resolves one quotient bit per pipeline stage for all
// three coordinates at once. The matrix resets to identity. When the result
// register is full and not taken, the whole pipeline holds.
`default_nettype none

module vertex_transform_perspective_divide #(
    parameter int FRAC_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  vtpd_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output vtpd_pkg::t_out_item o_out_item
);
    import vtpd_pkg::*;

    localparam int NW = 32 + FRAC_BITS;
    localparam int SW = 67 - FRAC_BITS;
    localparam logic [31:0] ONE = 32'(64'd1 << FRAC_BITS);
    localparam logic signed [SW-1:0] SMAX = SW'(64'sd2147483647);
    localparam logic signed [SW-1:0] SMIN = -SMAX - SW'(64'sd1);
    localparam logic [NW-1:0] QPOS = NW'(64'h7FFFFFFF);
    localparam logic [NW-1:0] QNEG = NW'(64'h80000000);

    logic en;

    logic                r_s0_valid;
    t_in_item            r_s0;
    logic signed [31:0]  r_mat [16];

    logic                r_s1_valid;
    logic signed [63:0]  r_s1_prod [3][4];
    logic signed [31:0]  r_s1_m3 [4];

    logic                r_s2_valid;
    logic signed [SW-1:0] r_s2_sum [4];
    logic signed [SW-1:0] n_s2_sum [4];

    logic                r_dv_valid [NW+1];
    logic [31:0]         r_dv_rem   [NW+1][3];
    logic [NW-1:0]       r_dv_nq    [NW+1][3];
    logic [31:0]         r_dv_d     [NW+1];
    logic                r_dv_neg   [NW+1][3];
    logic                r_dv_wz    [NW+1];
    logic                r_dv_sat   [NW+1];

    logic                r_out_valid;
    t_out_item           r_out;

    assign en          = !r_out_valid || i_out_ready;
    assign o_in_ready  = en;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (en) begin
            r_s0_valid <= i_in_valid;
            r_s0       <= i_in_item;
        end
    end

    // matrix: loads write as they pass the read point, keeping item order
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 16; i++) begin
                r_mat[i] <= (i == 0 || i == 5 || i == 10 || i == 15) ? ONE : '0;
            end
        end else if (en && r_s0_valid && r_s0.req_type == REQ_LOAD) begin
            r_mat[r_s0.entry_index] <= r_s0.entry_value;
        end
    end

    // products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid <= r_s0_valid && r_s0.req_type == REQ_XFORM;
            for (int c = 0; c < 4; c++) begin
                r_s1_prod[0][c] <= r_s0.vertex_x * r_mat[c];
                r_s1_prod[1][c] <= r_s0.vertex_y * r_mat[4+c];
                r_s1_prod[2][c] <= r_s0.vertex_z * r_mat[8+c];
                r_s1_m3[c]      <= r_mat[12+c];
            end
        end
    end

    // column sums, floored
    always_comb begin
        logic signed [65:0] tot;
        logic signed [65:0] sh;
        for (int c = 0; c < 4; c++) begin
            tot = 66'(r_s1_prod[0][c]) + 66'(r_s1_prod[1][c]) + 66'(r_s1_prod[2][c]);
            sh  = tot >>> FRAC_BITS;
            n_s2_sum[c] = SW'(sh) + SW'(r_s1_m3[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (en) begin
            r_s2_valid <= r_s1_valid;
            r_s2_sum   <= n_s2_sum;
        end
    end

    // clamp, split sign and magnitude, load divider head
    always_ff @(posedge i_clk) begin : p_clamp
        logic signed [31:0] cv [4];
        logic               sat;
        if (!i_rst_n) begin
            r_dv_valid[0] <= 1'b0;
        end else if (en) begin
            sat = 1'b0;
            for (int c = 0; c < 4; c++) begin
                if (r_s2_sum[c] > SMAX) begin
                    cv[c] = 32'sh7FFFFFFF;
                    sat   = 1'b1;
                end else if (r_s2_sum[c] < SMIN) begin
                    cv[c] = 32'sh80000000;
                    sat   = 1'b1;
                end else begin
                    cv[c] = 32'(r_s2_sum[c]);
                end
            end
            r_dv_valid[0] <= r_s2_valid;
            r_dv_d[0]     <= cv[3][31] ? -cv[3] : cv[3];
            r_dv_wz[0]    <= (cv[3] == '0);
            r_dv_sat[0]   <= sat;
            for (int j = 0; j < 3; j++) begin
                r_dv_rem[0][j] <= '0;
                r_dv_nq[0][j]  <= {(cv[j][31] ? -cv[j] : cv[j]), FRAC_BITS'(0)};
                r_dv_neg[0][j] <= cv[j][31] ^ cv[3][31];
            end
        end
    end

    // restoring divider, one quotient bit per stage
    for (genvar k = 1; k <= NW; k++) begin : g_dv
        always_ff @(posedge i_clk) begin : p_step
            logic [32:0] trial;
            logic [32:0] diff;
            if (!i_rst_n) begin
                r_dv_valid[k] <= 1'b0;
            end else if (en) begin
                r_dv_valid[k] <= r_dv_valid[k-1];
                r_dv_d[k]     <= r_dv_d[k-1];
                r_dv_wz[k]    <= r_dv_wz[k-1];
                r_dv_sat[k]   <= r_dv_sat[k-1];
                for (int j = 0; j < 3; j++) begin
                    trial = {r_dv_rem[k-1][j], r_dv_nq[k-1][j][NW-1]};
                    diff  = trial - {1'b0, r_dv_d[k-1]};
                    r_dv_rem[k][j] <= diff[32] ? trial[31:0] : diff[31:0];
                    r_dv_nq[k][j]  <= {r_dv_nq[k-1][j][NW-2:0], ~diff[32]};
                    r_dv_neg[k][j] <= r_dv_neg[k-1][j];
                end
            end
        end
    end

    // sign, saturation, result register
    always_ff @(posedge i_clk) begin : p_out
        logic [31:0] q [3];
        logic        qsat;
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            qsat = 1'b0;
            for (int j = 0; j < 3; j++) begin
                if (r_dv_wz[NW]) begin
                    q[j] = '0;
                end else if (!r_dv_neg[NW][j]) begin
                    if (r_dv_nq[NW][j] > QPOS) begin
                        q[j] = 32'h7FFFFFFF;
                        qsat = 1'b1;
                    end else begin
                        q[j] = r_dv_nq[NW][j][31:0];
                    end
                end else begin
                    if (r_dv_nq[NW][j] > QNEG) begin
                        q[j] = 32'h80000000;
                        qsat = 1'b1;
                    end else begin
                        q[j] = -r_dv_nq[NW][j][31:0];
                    end
                end
            end
            r_out_valid     <= r_dv_valid[NW];
            r_out.out_x     <= q[0];
            r_out.out_y     <= q[1];
            r_out.out_z     <= q[2];
            r_out.w_zero    <= r_dv_wz[NW];
            r_out.saturated <= r_dv_sat[NW] || qsat;
        end
    end

`ifndef SYNTHESIS
    a_wzero_outputs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.w_zero |->
            r_out.out_x == '0 && r_out.out_y == '0 && r_out.out_z == '0)
        else $error("w_zero result with nonzero outputs");

    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en && r_s0_valid && r_s0.req_type == REQ_LOAD |=> !r_s1_valid)
        else $error("load item entered the arithmetic pipeline");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en && r_s1_valid |=> r_s1_valid && $stable(r_s1_m3[3]))
        else $error("pipeline moved during stall");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_dv_valid[NW]))
        else $error("result without divider item");
`endif

endmodule

`default_nettype wire
